### rtl/scope_trigger_capture_core_macros.svh
// Assertion macros shared by the scope trigger capture RTL.
// Files that use these must have i_clk and i_rst_n in scope.
`ifndef SCOPE_TRIGGER_CAPTURE_CORE_MACROS_SVH
`define SCOPE_TRIGGER_CAPTURE_CORE_MACROS_SVH

// check expr on every edge outside reset
`define STC_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// check that cond implies expr on the next edge
`define STC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### rtl/stc_pkg.sv
// Shared constants, opcodes and types for the scope trigger capture core.
// No dependencies.
package stc_pkg;

    localparam int CAPTURE_DEPTH = 512;
    localparam int ADDR_W        = $clog2(CAPTURE_DEPTH);
    localparam int HALF_DEPTH    = CAPTURE_DEPTH / 2;
    localparam int COUNT_CAP     = 4 * CAPTURE_DEPTH - 1;
    localparam int COUNT_W       = $clog2(4 * CAPTURE_DEPTH);
    localparam int MAX_PICKS     = 32;
    localparam int PICK_W        = $clog2(MAX_PICKS + 1);
    localparam int SAMPLE_WIDTH  = 24;
    localparam int IN_W          = 24;
    localparam int INDEX_W       = 9;
    localparam int H_W           = 30;
    localparam int SUM_W         = H_W + 1;
    localparam int PHASE_W       = 25;
    localparam int STEP_W        = 24;
    localparam int COEF_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 24;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_COEF    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd2;

    localparam logic [STEP_W-1:0] RST_PHASE_STEP = 24'd65536;
    localparam logic [COEF_W-1:0] RST_HP_COEF    = 16'd65000;
    localparam logic [COEF_W-1:0] RST_GAIN       = 16'd4096;

    typedef struct packed {
        logic m1;
        logic m2;
        logic dstep;
        logic hstep;
        logic gstep;
    } t_lane_ctl;

endpackage

### rtl/stc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module stc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/stc_lane.sv
// One channel of the pick datapath: DC-removing one-pole filter and gain.
// Depends on stc_pkg; steps through multiply, filter update, high-pass, gain.
module stc_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  stc_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [stc_pkg::IN_W-1:0]      i_x,
    input  logic [stc_pkg::COEF_W-1:0]           i_coef,
    input  logic [stc_pkg::COEF_W-1:0]           i_gain,
    output logic signed [stc_pkg::H_W-1:0]       o_h,
    output logic signed [stc_pkg::SAMPLE_WIDTH-1:0] o_value
);
    import stc_pkg::*;

    logic signed [39:0]    r_dc;
    logic signed [41:0]    r_a;
    logic [35:0]           r_blo;
    logic signed [36:0]    r_bhi;
    logic signed [H_W-1:0] r_h;
    logic signed [46:0]    r_g;

    logic [16:0]        w_pole;
    logic signed [41:0] w_a;
    logic [35:0]        w_blo;
    logic signed [36:0] w_bhi;
    logic signed [57:0] w_v;
    logic signed [41:0] w_draw;
    logic signed [39:0] w_d;
    logic signed [41:0] w_hv;
    logic signed [46:0] w_gv;
    logic signed [34:0] w_s;
    logic               w_s_ok;

    always_comb begin
        w_pole = 17'(17'd65536 - {1'b0, i_coef});
        w_a    = $signed({1'b0, w_pole}) * i_x;
        w_blo  = i_coef * r_dc[19:0];
        w_bhi  = $signed({1'b0, i_coef}) * $signed(r_dc[39:20]);
        w_v    = $signed({r_a[41], r_a, 15'b0}) + $signed({r_bhi[36], r_bhi, 20'b0})
               + $signed({22'b0, r_blo}) + 58'sd32768;
        w_draw = w_v[57:16];
        if (w_draw[41:39] == 3'b000 || w_draw[41:39] == 3'b111) begin
            w_d = w_draw[39:0];
        end else if (w_draw[41]) begin
            w_d = {1'b1, 39'b0};
        end else begin
            w_d = {1'b0, {39{1'b1}}};
        end
        w_hv   = $signed({{3{i_x[IN_W-1]}}, i_x, 15'b0}) - $signed({{2{r_dc[39]}}, r_dc})
               + 42'sd2048;
        w_gv   = r_g + 47'sd2048;
        w_s    = w_gv[46:12];
        w_s_ok = (&w_s[34:SAMPLE_WIDTH-1]) || !(|w_s[34:SAMPLE_WIDTH-1]);
        if (w_s_ok) begin
            o_value = w_s[SAMPLE_WIDTH-1:0];
        end else if (w_s[34]) begin
            o_value = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end else begin
            o_value = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc <= '0;
        end else if (i_ctl.dstep) begin
            r_dc <= w_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.m1) begin
            r_a   <= w_a;
            r_blo <= w_blo;
        end
        if (i_ctl.m2) begin
            r_bhi <= w_bhi;
        end
        if (i_ctl.hstep) begin
            r_h <= w_hv[41:12];
        end
        if (i_ctl.gstep) begin
            r_g <= r_h * $signed({1'b0, i_gain});
        end
    end

    assign o_h = r_h;
endmodule

### rtl/scope_trigger_capture_core.sv
// Scope trigger capture core. A push op resamples the stereo pair by a
// Q9.16 phase accumulator into 0..32 picks; each pick steps the filter
// lanes through M1 and M2 for the 16x40 pole multiply, then filter update,
// high-pass, gain and ring write. A read op goes through the S_RD state
// for the registered ring memory read; release and no-op answer from idle.
// One op is in flight at a time. Depends on stc_pkg, stc_ram, stc_lane.
module scope_trigger_capture_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [1:0]                              i_opcode,
    input  logic signed [stc_pkg::IN_W-1:0]         i_sample_left,
    input  logic signed [stc_pkg::IN_W-1:0]         i_sample_right,
    input  logic [stc_pkg::INDEX_W-1:0]             i_read_index,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_capture_ready,
    output logic signed [stc_pkg::SAMPLE_WIDTH-1:0] o_read_left,
    output logic signed [stc_pkg::SAMPLE_WIDTH-1:0] o_read_right,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [stc_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]          i_cfg_data
);
    import stc_pkg::*;
    `include "scope_trigger_capture_core_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_M1   = 3'd2;
    localparam logic [2:0] S_M2   = 3'd3;
    localparam logic [2:0] S_D    = 3'd4;
    localparam logic [2:0] S_H    = 3'd5;
    localparam logic [2:0] S_G    = 3'd6;
    localparam logic [2:0] S_W    = 3'd7;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(65536);

    logic [2:0]               r_state, n_state;
    logic [STEP_W-1:0]        r_step;
    logic [COEF_W-1:0]        r_coef;
    logic [COEF_W-1:0]        r_gain;
    logic [PHASE_W-1:0]       r_phase, n_phase;
    logic [PICK_W-1:0]        r_picks, n_picks;
    logic [ADDR_W-1:0]        r_wp, n_wp;
    logic [ADDR_W-1:0]        r_endp, n_endp;
    logic [COUNT_W-1:0]       r_wc, n_wc;
    logic [COUNT_W-1:0]       r_ac, n_ac;
    logic                     r_trig, n_trig;
    logic                     r_done, n_done;
    logic signed [SUM_W-1:0]  r_prev, n_prev;
    logic signed [IN_W-1:0]   r_xl, r_xr;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_ready, n_out_ready;
    logic signed [SAMPLE_WIDTH-1:0] r_out_l, n_out_l, r_out_r, n_out_r;

    t_lane_ctl                      w_ctl;
    logic signed [H_W-1:0]          w_hl, w_hr;
    logic signed [SAMPLE_WIDTH-1:0] w_vl, w_vr, w_rl, w_rr;
    logic signed [SUM_W-1:0]        w_sum;
    logic                           w_in_acc, w_out_take, w_we, w_fire;
    logic [ADDR_W-1:0]              w_raddr;
    logic [PHASE_W-1:0]             w_phase_add;
    logic [PICK_W-1:0]              w_picks_inc;
    logic [ADDR_W-1:0]              w_wp_inc;

    assign o_stall     = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_take  = r_out_valid && !i_stall;
    assign o_cfg_ready = 1'b1;

    assign w_ctl.m1    = (r_state == S_M1);
    assign w_ctl.m2    = (r_state == S_M2);
    assign w_ctl.dstep = (r_state == S_D);
    assign w_ctl.hstep = (r_state == S_H);
    assign w_ctl.gstep = (r_state == S_G);

    stc_lane u_lane_l (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_x(r_xl), .i_coef(r_coef), .i_gain(r_gain),
        .o_h(w_hl), .o_value(w_vl)
    );
    stc_lane u_lane_r (
        .i_clk, .i_rst_n, .i_ctl(w_ctl), .i_x(r_xr), .i_coef(r_coef), .i_gain(r_gain),
        .o_h(w_hr), .o_value(w_vr)
    );

    assign w_we    = (r_state == S_W);
    assign w_raddr = ADDR_W'(r_endp + ADDR_W'(i_read_index));

    stc_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(CAPTURE_DEPTH)) u_ring_l (
        .i_clk, .i_we(w_we), .i_waddr(r_wp), .i_wdata(w_vl), .i_raddr(w_raddr),
        .o_rdata(w_rl)
    );
    stc_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(CAPTURE_DEPTH)) u_ring_r (
        .i_clk, .i_we(w_we), .i_waddr(r_wp), .i_wdata(w_vr), .i_raddr(w_raddr),
        .o_rdata(w_rr)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_picks     = r_picks;
        n_wp        = r_wp;
        n_endp      = r_endp;
        n_wc        = r_wc;
        n_ac        = r_ac;
        n_trig      = r_trig;
        n_done      = r_done;
        n_prev      = r_prev;
        n_out_valid = r_out_valid && !w_out_take;
        n_out_ready = r_out_ready;
        n_out_l     = r_out_l;
        n_out_r     = r_out_r;
        w_sum       = SUM_W'(w_hl) + SUM_W'(w_hr);
        w_fire      = 1'b0;
        w_phase_add = PHASE_W'(r_phase + PHASE_W'(r_step));
        w_picks_inc = PICK_W'(r_picks + 1'b1);
        w_wp_inc    = ADDR_W'(r_wp + 1'b1);

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_out_l = '0;
                    n_out_r = '0;
                    priority if (i_opcode == OP_PUSH && !r_done) begin
                        if (r_phase < PHASE_ONE) begin
                            n_picks = '0;
                            n_state = S_M1;
                        end else begin
                            n_phase     = PHASE_W'(r_phase - PHASE_ONE);
                            n_out_valid = 1'b1;
                            n_out_ready = r_done;
                        end
                    end else if (i_opcode == OP_READ && r_done) begin
                        n_state = S_RD;
                    end else begin
                        if (i_opcode == OP_RELEASE) begin
                            n_done = 1'b0;
                        end
                        n_out_valid = 1'b1;
                        n_out_ready = (i_opcode == OP_RELEASE) ? 1'b0 : r_done;
                    end
                end
            end
            S_RD: begin
                n_out_valid = 1'b1;
                n_out_ready = r_done;
                n_out_l     = w_rl;
                n_out_r     = w_rr;
                n_state     = S_IDLE;
            end
            S_M1: n_state = S_M2;
            S_M2: n_state = S_D;
            S_D:  n_state = S_H;
            S_H:  n_state = S_G;
            S_G:  n_state = S_W;
            S_W: begin
                if (!r_trig && r_wc > COUNT_W'(HALF_DEPTH)) begin
                    w_fire = (w_sum < 0 && r_prev > 0) || (r_ac > COUNT_W'(HALF_DEPTH));
                    if (w_fire) begin
                        n_trig = 1'b1;
                        n_endp = ADDR_W'(r_wp + ADDR_W'(HALF_DEPTH));
                        n_ac   = COUNT_W'(1);
                    end else begin
                        n_ac = COUNT_W'(r_ac + 1'b1);
                    end
                end
                n_prev = w_sum;
                n_wc   = (r_wc < COUNT_W'(COUNT_CAP)) ? COUNT_W'(r_wc + 1'b1) : r_wc;
                n_wp   = w_wp_inc;
                n_picks = w_picks_inc;
                if (n_trig && w_wp_inc == n_endp) begin
                    n_trig      = 1'b0;
                    n_done      = 1'b1;
                    n_wc        = '0;
                    n_phase     = '0;
                    n_out_valid = 1'b1;
                    n_out_ready = 1'b1;
                    n_state     = S_IDLE;
                end else if (w_phase_add < PHASE_ONE && w_picks_inc < PICK_W'(MAX_PICKS)) begin
                    n_phase = w_phase_add;
                    n_state = S_M1;
                end else begin
                    n_phase     = (w_phase_add < PHASE_ONE) ? '0
                                : PHASE_W'(w_phase_add - PHASE_ONE);
                    n_out_valid = 1'b1;
                    n_out_ready = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= RST_PHASE_STEP;
            r_coef      <= RST_HP_COEF;
            r_gain      <= RST_GAIN;
            r_phase     <= '0;
            r_picks     <= '0;
            r_wp        <= '0;
            r_endp      <= '0;
            r_wc        <= '0;
            r_ac        <= '0;
            r_trig      <= 1'b0;
            r_done      <= 1'b0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
            r_out_ready <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_picks     <= n_picks;
            r_wp        <= n_wp;
            r_endp      <= n_endp;
            r_wc        <= n_wc;
            r_ac        <= n_ac;
            r_trig      <= n_trig;
            r_done      <= n_done;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
            r_out_ready <= n_out_ready;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PHASE_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                    CFG_HP_COEF:    r_coef <= i_cfg_data[COEF_W-1:0];
                    CFG_GAIN:       r_gain <= i_cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_l <= n_out_l;
        r_out_r <= n_out_r;
        if (w_in_acc) begin
            r_xl <= i_sample_left;
            r_xr <= i_sample_right;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_capture_ready = r_out_ready;
    assign o_read_left     = r_out_l;
    assign o_read_right    = r_out_r;

    `STC_ASSERT(a_trig_excl_done, !(r_trig && r_done), "trigger armed while capture done")
    `STC_ASSERT(a_no_pick_when_done, (r_state == S_IDLE || r_state == S_RD) || !r_done, "pick stage ran with capture done")
    `STC_ASSERT(a_pick_cap, r_picks <= PICK_W'(MAX_PICKS), "pick count beyond cap")
    `STC_ASSERT_NEXT(a_release_clears, w_in_acc && i_opcode == OP_RELEASE, !r_done, "release left capture done set")
endmodule
